[sv/scd_pkg.sv]
// Shared types and constants for the set-1 scan code to ASCII decoder.
// No dependencies; used by scd_keymap, scd_core and the top level.
package scd_pkg;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [7:0] TABLE_LEN   = 8'h3A;

  // Key codes with the release bit stripped
  localparam logic [6:0] KEY_SHIFT_L = 7'h2A;
  localparam logic [6:0] KEY_SHIFT_R = 7'h36;
  localparam logic [6:0] KEY_CTRL    = 7'h1D;
  localparam logic [6:0] KEY_ALT     = 7'h38;
  localparam logic [6:0] KEY_TAB     = 7'h0F;
  localparam logic [6:0] KEY_WIN_L   = 7'h5B;
  localparam logic [6:0] KEY_WIN_R   = 7'h5C;
  localparam logic [6:0] KEY_UP      = 7'h48;
  localparam logic [6:0] KEY_DOWN    = 7'h50;
  localparam logic [6:0] KEY_LEFT    = 7'h4B;
  localparam logic [6:0] KEY_RIGHT   = 7'h4D;

  localparam logic [6:0] ASCII_LC_C = 7'h63;
  localparam logic [6:0] ASCII_UC_C = 7'h43;
  localparam logic [6:0] ASCII_LC_L = 7'h6C;
  localparam logic [6:0] ASCII_UC_L = 7'h4C;

  typedef enum logic [2:0] {
    NAV_NONE  = 3'd0,
    NAV_UP    = 3'd1,
    NAV_DOWN  = 3'd2,
    NAV_LEFT  = 3'd3,
    NAV_RIGHT = 3'd4,
    NAV_LWIN  = 3'd5,
    NAV_RWIN  = 3'd6
  } nav_t;

  // Listed from the top bit down, so char_valid lands in bit 0
  typedef struct packed {
    logic       win_held;
    logic       alt_held;
    logic       ctrl_held;
    logic       shift_held;
    nav_t       nav_key;
    logic       clear_event;
    logic       interrupt_event;
    logic [6:0] char_code;
    logic       char_valid;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

[sv/scd_keymap.sv]
// US-layout set-1 key map: plain and shifted ASCII for codes below 0x3A.
// Depends on scd_pkg.
module scd_keymap (
  input  logic [7:0] code,
  input  logic       shift,
  output logic [6:0] ch
);

  localparam int MapLen = 58;

  localparam logic [6:0] PLAIN_MAP [MapLen] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  localparam logic [6:0] SHIFT_MAP [MapLen] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  always_comb begin
    if (code < scd_pkg::TABLE_LEN) begin
      ch = shift ? SHIFT_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
    end else begin
      ch = 7'h00;
    end
  end

endmodule

[sv/scd_core.sv]
// Modifier/prefix flag state and per-word decode of one scan code.
// Depends on scd_pkg and scd_keymap.
module scd_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              code,
  output scd_pkg::result_t        res
);

  logic shift_flag, ctrl_flag, alt_flag, win_flag, tab_flag, prefix_seen;
  logic shift_flag_next, ctrl_flag_next, alt_flag_next, win_flag_next, tab_flag_next;
  logic prefix_seen_next;

  logic       is_prefix;
  logic       level;
  logic [6:0] key;
  logic       press;
  logic       plain_hit;
  logic [6:0] ch;
  scd_pkg::nav_t nav;

  function automatic scd_pkg::nav_t nav_lookup(input logic [6:0] k);
    scd_pkg::nav_t n;
    n = scd_pkg::NAV_NONE;
    if (k == scd_pkg::KEY_UP)         n = scd_pkg::NAV_UP;
    else if (k == scd_pkg::KEY_DOWN)  n = scd_pkg::NAV_DOWN;
    else if (k == scd_pkg::KEY_LEFT)  n = scd_pkg::NAV_LEFT;
    else if (k == scd_pkg::KEY_RIGHT) n = scd_pkg::NAV_RIGHT;
    else if (k == scd_pkg::KEY_WIN_L) n = scd_pkg::NAV_LWIN;
    else if (k == scd_pkg::KEY_WIN_R) n = scd_pkg::NAV_RWIN;
    return n;
  endfunction

  // Flag update; the prefix held before this word picks the extended set
  always_comb begin
    is_prefix        = (code == scd_pkg::PREFIX_BYTE);
    level            = ~code[7];
    key              = code[6:0];
    shift_flag_next  = shift_flag;
    ctrl_flag_next   = ctrl_flag;
    alt_flag_next    = alt_flag;
    win_flag_next    = win_flag;
    tab_flag_next    = tab_flag;
    prefix_seen_next = is_prefix;
    if (!is_prefix) begin
      if (prefix_seen) begin
        priority if (key == scd_pkg::KEY_WIN_L || key == scd_pkg::KEY_WIN_R) begin
          win_flag_next = level;
        end else if (key == scd_pkg::KEY_CTRL) begin
          ctrl_flag_next = level;
        end else if (key == scd_pkg::KEY_ALT) begin
          alt_flag_next = level;
        end
      end else begin
        priority if (key == scd_pkg::KEY_SHIFT_L || key == scd_pkg::KEY_SHIFT_R) begin
          shift_flag_next = level;
        end else if (key == scd_pkg::KEY_CTRL) begin
          ctrl_flag_next = level;
        end else if (key == scd_pkg::KEY_ALT) begin
          alt_flag_next = level;
        end else if (key == scd_pkg::KEY_TAB) begin
          tab_flag_next = level;
        end
      end
    end
  end

  scd_keymap u_keymap (
    .code  (code),
    .shift (shift_flag_next),
    .ch    (ch)
  );

  always_comb begin
    press     = !is_prefix && !code[7];
    nav       = (press && prefix_seen) ? nav_lookup(key) : scd_pkg::NAV_NONE;
    plain_hit = press && !prefix_seen && (ch != 7'h00);

    res.char_valid      = plain_hit && !ctrl_flag_next;
    res.char_code       = (plain_hit && !ctrl_flag_next) ? ch : 7'h00;
    res.interrupt_event = plain_hit && ctrl_flag_next &&
                          (ch == scd_pkg::ASCII_LC_C || ch == scd_pkg::ASCII_UC_C);
    res.clear_event     = plain_hit && ctrl_flag_next &&
                          (ch == scd_pkg::ASCII_LC_L || ch == scd_pkg::ASCII_UC_L);
    res.nav_key         = nav;
    res.shift_held      = shift_flag_next;
    res.ctrl_held       = ctrl_flag_next;
    res.alt_held        = alt_flag_next;
    res.win_held        = win_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_flag  <= 1'b0;
      ctrl_flag   <= 1'b0;
      alt_flag    <= 1'b0;
      win_flag    <= 1'b0;
      tab_flag    <= 1'b0;
      prefix_seen <= 1'b0;
    end else if (step) begin
      shift_flag  <= shift_flag_next;
      ctrl_flag   <= ctrl_flag_next;
      alt_flag    <= alt_flag_next;
      win_flag    <= win_flag_next;
      tab_flag    <= tab_flag_next;
      prefix_seen <= prefix_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_prefix_sets_flag: assert property (@(posedge clk) disable iff (rst)
    step && (code == scd_pkg::PREFIX_BYTE) |=> prefix_seen)
    else $error("prefix word did not set the prefix flag");

  a_tab_press: assert property (@(posedge clk) disable iff (rst)
    step && !prefix_seen && (code == {1'b0, scd_pkg::KEY_TAB}) |=> tab_flag)
    else $error("tab press did not set the tab flag");

  a_ctrl_holds_char: assert property (@(posedge clk) disable iff (rst)
    res.char_valid |-> !ctrl_flag_next)
    else $error("character delivered while control held");
`endif

endmodule

[sv/scan_code_to_ascii_decoder.sv]
// Top level of the set-1 scan code to ASCII decoder: input word register,
// decode core and result register. Depends on scd_pkg and scd_core.
//
// Usage:
//   Slave channel (s_*) takes one raw set-1 scan code byte per word.
//   Master channel (m_*) gives exactly one result word per input word, in order.
//   Path: an accepted word is held in the input register, then decoded and
//   loaded into the result register, which raises m_tvalid.
//   Throughput: one word per cycle while m_tready is high. The decode is a
//   table lookup and flag update that fits between the input register and the
//   result register; the modifier flags are registered as each word moves on,
//   so a word can follow every cycle.
//   Stall: while m_tready is low the result register holds its word; an empty
//   input register still takes one more word, then s_tready stays low until
//   the result is taken. Nothing is lost or repeated.
//   Reset (rst, synchronous, active high) empties both registers and clears
//   the shift, control, alt, windows, tab and extended-prefix flags.
module scan_code_to_ascii_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // [7:0] scan_code
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [0] char_valid, [7:1] char_code, [8] interrupt_event, [9] clear_event,
  // [12:10] nav_key, [13] shift_held, [14] ctrl_held, [15] alt_held,
  // [16] win_held, [23:17] zero
  output logic [scd_pkg::TDATA_W-1:0] m_tdata
);

  // Input word register
  logic       in_valid;
  logic [7:0] in_code;

  // Result register
  logic              out_valid;
  scd_pkg::result_t  out_res;
  scd_pkg::result_t  res;

  logic advance;
  logic take_in;

  // The held word moves on when the result register is empty or being emptied
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign take_in  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take_in) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_code <= s_tdata;
    end
  end

  scd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .code (in_code),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(scd_pkg::TDATA_W - scd_pkg::RESULT_W){1'b0}}, out_res};

`ifndef SYNTHESIS
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones({out_res.char_valid, out_res.interrupt_event,
                             out_res.clear_event, out_res.nav_key != scd_pkg::NAV_NONE}) <= 1)
    else $error("more than one outcome in a result word");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("decoded word did not reach the result register");

  a_stall_keeps_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_code))
    else $error("held input word lost during stall");

  a_char_code_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_res.char_valid |-> out_res.char_code == 7'h00)
    else $error("character code set without a character");
`endif

endmodule
